>>> rtl/random_quaternion_vector_rotation_unit_macros.svh
// Assertion macros for the random quaternion vector rotation unit.
// Expects signals named clock and reset in the including module.
`ifndef RANDOM_QUATERNION_VECTOR_ROTATION_UNIT_MACROS_SVH
`define RANDOM_QUATERNION_VECTOR_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RQVR_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rqvr check failed");

// Next-cycle implication, off during reset.
`define RQVR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rqvr check failed");

`endif

>>> rtl/rqvr_pkg.sv
// Shared types, constants and the arctangent table of the rotation unit.
// No dependencies.
package rqvr_pkg;

   localparam int SQRT_STEPS   = 15;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
   localparam logic signed [34:0] ONE_Q28      = 35'sd268435456;

   typedef enum logic [1:0] {
      CSR_VEC_X = 2'd0,
      CSR_VEC_Y = 2'd1,
      CSR_VEC_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [16:0] unif_a;
      logic [16:0] unif_b;
      logic [16:0] unif_c;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] quat_real;
      logic signed [15:0] quat_i;
      logic signed [15:0] quat_j;
      logic signed [15:0] quat_k;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
   } rsp_item_type;

   // Two square roots in flight: ri for sqrt(1-u1), jk for sqrt(u1).
   typedef struct packed {
      logic        valid;
      logic [28:0] x_ri;
      logic [28:0] r_ri;
      logic [28:0] x_jk;
      logic [28:0] r_jk;
      logic [15:0] ang_b;
      logic [15:0] ang_c;
   } sqrt_lane_type;

   // Two CORDIC rotations in flight plus the finished roots.
   typedef struct packed {
      logic               valid;
      logic [1:0]         quad_b;
      logic signed [32:0] x_b;
      logic signed [32:0] y_b;
      logic signed [32:0] z_b;
      logic [1:0]         quad_c;
      logic signed [32:0] x_c;
      logic signed [32:0] y_c;
      logic signed [32:0] z_c;
      logic [14:0]        root_ri;
      logic [14:0]        root_jk;
   } cordic_lane_type;

   // atan(2^-i) as a 32-bit fraction of a turn.
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] val;
      unique case (idx)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/rqvr_sqrt_cell.sv
// One digit step of the two integer square roots, registered.
// Depends on rqvr_pkg.
module rqvr_sqrt_cell
   import rqvr_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  sqrt_lane_type src,
   output sqrt_lane_type dst
);

   localparam logic [29:0] BIT = 30'(1) << (28 - 2 * STEP);

   sqrt_lane_type step_in;
   sqrt_lane_type step_ff;
   logic          valid_ff;
   logic [29:0]   trial_ri;
   logic [29:0]   trial_jk;

   assign trial_ri = {1'b0, src.r_ri} + BIT;
   assign trial_jk = {1'b0, src.r_jk} + BIT;

   always_comb begin
      step_in = src;
      if ({1'b0, src.x_ri} >= trial_ri) begin
         step_in.x_ri = 29'({1'b0, src.x_ri} - trial_ri);
         step_in.r_ri = 29'({1'b0, src.r_ri >> 1} + BIT);
      end else begin
         step_in.r_ri = src.r_ri >> 1;
      end
      if ({1'b0, src.x_jk} >= trial_jk) begin
         step_in.x_jk = 29'({1'b0, src.x_jk} - trial_jk);
         step_in.r_jk = 29'({1'b0, src.r_jk >> 1} + BIT);
      end else begin
         step_in.r_jk = src.r_jk >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= src.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      dst       = step_ff;
      dst.valid = valid_ff;
   end

endmodule

>>> rtl/rqvr_cordic_cell.sv
// One CORDIC rotation step for both angles, registered.
// Depends on rqvr_pkg.
module rqvr_cordic_cell
   import rqvr_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  cordic_lane_type src,
   output cordic_lane_type dst
);

   localparam logic signed [32:0] ATAN = 33'($signed({1'b0, atan_turn(STEP)}));

   cordic_lane_type step_in;
   cordic_lane_type step_ff;
   logic            valid_ff;

   always_comb begin
      step_in = src;
      if (src.z_b >= 0) begin
         step_in.x_b = src.x_b - (src.y_b >>> STEP);
         step_in.y_b = src.y_b + (src.x_b >>> STEP);
         step_in.z_b = src.z_b - ATAN;
      end else begin
         step_in.x_b = src.x_b + (src.y_b >>> STEP);
         step_in.y_b = src.y_b - (src.x_b >>> STEP);
         step_in.z_b = src.z_b + ATAN;
      end
      if (src.z_c >= 0) begin
         step_in.x_c = src.x_c - (src.y_c >>> STEP);
         step_in.y_c = src.y_c + (src.x_c >>> STEP);
         step_in.z_c = src.z_c - ATAN;
      end else begin
         step_in.x_c = src.x_c + (src.y_c >>> STEP);
         step_in.y_c = src.y_c - (src.x_c >>> STEP);
         step_in.z_c = src.z_c + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= src.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      dst       = step_ff;
      dst.valid = valid_ff;
   end

endmodule

>>> rtl/random_quaternion_vector_rotation_unit.sv
// A request runs through the sqrt cells, the CORDIC cells, then the qprod, quat, pair, mat and term registers to rsp.
// Throughput: one item per cycle; the whole pipe advances together and
// stalls only while a finished item sits in the output register unread.
// Reset (synchronous, high) empties every stage and loads the vector
// registers with x=256, y=1792, z=2048.
// Depends on rqvr_pkg, rqvr_sqrt_cell, rqvr_cordic_cell and the macro header.
`include "random_quaternion_vector_rotation_unit_macros.svh"
module random_quaternion_vector_rotation_unit
   import rqvr_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   // ---------------------------------------------------------------
   // Vector registers
   // ---------------------------------------------------------------
   logic signed [15:0] vec_x_ff;
   logic signed [15:0] vec_y_ff;
   logic signed [15:0] vec_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_x_ff <= 16'sd256;
         vec_y_ff <= 16'sd1792;
         vec_z_ff <= 16'sd2048;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VEC_X: vec_x_ff <= csr_wdata;
            CSR_VEC_Y: vec_y_ff <= csr_wdata;
            CSR_VEC_Z: vec_z_ff <= csr_wdata;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // Advance the whole pipe unless the output holds an item not yet taken.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------
   // Square root chain: sqrt(u * 4096), one digit per cell
   // ---------------------------------------------------------------
   sqrt_lane_type sqrt_lane [SQRT_STEPS+1];
   logic [16:0]   unif_a_sat;

   // Clamp u1 to one; angles wrap at a full turn.
   assign unif_a_sat = (req_item.unif_a > 17'd65536) ? 17'd65536 : req_item.unif_a;

   always_comb begin
      sqrt_lane[0].valid = req_valid;
      sqrt_lane[0].x_ri  = {17'd65536 - unif_a_sat, 12'd0};
      sqrt_lane[0].r_ri  = '0;
      sqrt_lane[0].x_jk  = {unif_a_sat, 12'd0};
      sqrt_lane[0].r_jk  = '0;
      sqrt_lane[0].ang_b = req_item.unif_b[15:0];
      sqrt_lane[0].ang_c = req_item.unif_c[15:0];
   end

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      rqvr_sqrt_cell #(.STEP(s)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .src    (sqrt_lane[s]),
         .dst    (sqrt_lane[s+1])
      );
   end

   // ---------------------------------------------------------------
   // Round the roots, seed the CORDIC chain
   // ---------------------------------------------------------------
   cordic_lane_type cordic_lane [CORDIC_STAGES+1];
   sqrt_lane_type   sqrt_done;

   assign sqrt_done = sqrt_lane[SQRT_STEPS];

   always_comb begin
      cordic_lane[0].valid   = sqrt_done.valid;
      cordic_lane[0].root_ri = 15'(sqrt_done.r_ri
                                   + ((sqrt_done.x_ri > sqrt_done.r_ri) ? 29'd1 : 29'd0));
      cordic_lane[0].root_jk = 15'(sqrt_done.r_jk
                                   + ((sqrt_done.x_jk > sqrt_done.r_jk) ? 29'd1 : 29'd0));
      cordic_lane[0].quad_b  = sqrt_done.ang_b[15:14];
      cordic_lane[0].x_b     = CORDIC_START;
      cordic_lane[0].y_b     = '0;
      cordic_lane[0].z_b     = $signed({3'b000, sqrt_done.ang_b[13:0], 16'd0});
      cordic_lane[0].quad_c  = sqrt_done.ang_c[15:14];
      cordic_lane[0].x_c     = CORDIC_START;
      cordic_lane[0].y_c     = '0;
      cordic_lane[0].z_c     = $signed({3'b000, sqrt_done.ang_c[13:0], 16'd0});
   end

   for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
      rqvr_cordic_cell #(.STEP(c)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .src    (cordic_lane[c]),
         .dst    (cordic_lane[c+1])
      );
   end

   // ---------------------------------------------------------------
   // Quadrant fold, then root times trig
   // ---------------------------------------------------------------
   cordic_lane_type    cdone;
   logic signed [32:0] sin_b, cos_b, sin_c, cos_c;

   assign cdone = cordic_lane[CORDIC_STAGES];

   always_comb begin
      case (cdone.quad_b)
         2'd0:    begin cos_b = cdone.x_b;  sin_b = cdone.y_b;  end
         2'd1:    begin cos_b = -cdone.y_b; sin_b = cdone.x_b;  end
         2'd2:    begin cos_b = -cdone.x_b; sin_b = -cdone.y_b; end
         default: begin cos_b = cdone.y_b;  sin_b = -cdone.x_b; end
      endcase
      case (cdone.quad_c)
         2'd0:    begin cos_c = cdone.x_c;  sin_c = cdone.y_c;  end
         2'd1:    begin cos_c = -cdone.y_c; sin_c = cdone.x_c;  end
         2'd2:    begin cos_c = -cdone.x_c; sin_c = -cdone.y_c; end
         default: begin cos_c = cdone.y_c;  sin_c = -cdone.x_c; end
      endcase
   end

   logic               qprod_valid_ff;
   logic signed [48:0] qprod_ff [4];
   logic signed [15:0] root_ri_s, root_jk_s;

   assign root_ri_s = $signed({1'b0, cdone.root_ri});
   assign root_jk_s = $signed({1'b0, cdone.root_jk});

   always_ff @(posedge clock) begin
      if (advance) begin
         qprod_ff[0] <= root_ri_s * sin_b;
         qprod_ff[1] <= root_ri_s * cos_b;
         qprod_ff[2] <= root_jk_s * sin_c;
         qprod_ff[3] <= root_jk_s * cos_c;
      end
   end

   // Round to Q1.14 and clamp to plus or minus one.
   function automatic logic signed [15:0] quat_round(input logic signed [48:0] p);
      logic signed [49:0] sum;
      logic signed [19:0] v;
      sum = 50'(p) + 50'sd536870912;
      v   = 20'(sum >>> 30);
      if (v > 20'sd16384) begin
         return 16'sd16384;
      end else if (v < -20'sd16384) begin
         return -16'sd16384;
      end
      return 16'(v);
   endfunction

   logic               quat_valid_ff;
   logic signed [15:0] quat_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int q = 0; q < 4; q++) begin
            quat_ff[q] <= quat_round(qprod_ff[q]);
         end
      end
   end

   // ---------------------------------------------------------------
   // Quaternion products, matrix entries, matrix times vector
   // ---------------------------------------------------------------
   // quat_ff: 0 real, 1 i, 2 j, 3 k
   // pair_ff: 0 ii, 1 jj, 2 kk, 3 ij, 4 ik, 5 jk, 6 ir, 7 jr, 8 kr
   logic               pair_valid_ff;
   logic signed [31:0] pair_ff [9];

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff[0] <= quat_ff[1] * quat_ff[1];
         pair_ff[1] <= quat_ff[2] * quat_ff[2];
         pair_ff[2] <= quat_ff[3] * quat_ff[3];
         pair_ff[3] <= quat_ff[1] * quat_ff[2];
         pair_ff[4] <= quat_ff[1] * quat_ff[3];
         pair_ff[5] <= quat_ff[2] * quat_ff[3];
         pair_ff[6] <= quat_ff[1] * quat_ff[0];
         pair_ff[7] <= quat_ff[2] * quat_ff[0];
         pair_ff[8] <= quat_ff[3] * quat_ff[0];
      end
   end

   function automatic logic signed [34:0] diag_entry(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
      return ONE_Q28 - ((35'(a) + 35'(b)) <<< 1);
   endfunction

   function automatic logic signed [34:0] off_entry(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic              sub);
      return sub ? ((35'(a) - 35'(b)) <<< 1) : ((35'(a) + 35'(b)) <<< 1);
   endfunction

   // mat_ff is row major.
   logic               mat_valid_ff;
   logic signed [34:0] mat_ff [9];

   always_ff @(posedge clock) begin
      if (advance) begin
         mat_ff[0] <= diag_entry(pair_ff[1], pair_ff[2]);
         mat_ff[1] <= off_entry(pair_ff[3], pair_ff[8], 1'b1);
         mat_ff[2] <= off_entry(pair_ff[4], pair_ff[7], 1'b0);
         mat_ff[3] <= off_entry(pair_ff[3], pair_ff[8], 1'b0);
         mat_ff[4] <= diag_entry(pair_ff[0], pair_ff[2]);
         mat_ff[5] <= off_entry(pair_ff[5], pair_ff[6], 1'b1);
         mat_ff[6] <= off_entry(pair_ff[4], pair_ff[7], 1'b1);
         mat_ff[7] <= off_entry(pair_ff[5], pair_ff[6], 1'b0);
         mat_ff[8] <= diag_entry(pair_ff[0], pair_ff[1]);
      end
   end

   logic               term_valid_ff;
   logic signed [50:0] term_ff [9];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            term_ff[3*r]   <= mat_ff[3*r]   * vec_x_ff;
            term_ff[3*r+1] <= mat_ff[3*r+1] * vec_y_ff;
            term_ff[3*r+2] <= mat_ff[3*r+2] * vec_z_ff;
         end
      end
   end

   // Sum one row, round from Q.28 to Q7.8, saturate to 16 bits.
   function automatic logic signed [15:0] row_round(input logic signed [50:0] t0,
                                                    input logic signed [50:0] t1,
                                                    input logic signed [50:0] t2);
      logic signed [52:0] acc;
      logic signed [24:0] v;
      acc = 53'(t0) + 53'(t1) + 53'(t2) + 53'sd134217728;
      v   = 25'(acc >>> 28);
      if (v > 25'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -25'sd32768) begin
         return -16'sd32768;
      end
      return 16'(v);
   endfunction

   // ---------------------------------------------------------------
   // Output register and the valid line through the arithmetic stages
   // ---------------------------------------------------------------
   rsp_item_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qprod_valid_ff <= 1'b0;
         quat_valid_ff  <= 1'b0;
         pair_valid_ff  <= 1'b0;
         mat_valid_ff   <= 1'b0;
         term_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         qprod_valid_ff <= cdone.valid;
         quat_valid_ff  <= qprod_valid_ff;
         pair_valid_ff  <= quat_valid_ff;
         mat_valid_ff   <= pair_valid_ff;
         term_valid_ff  <= mat_valid_ff;
         rsp_valid_ff   <= term_valid_ff;
      end
   end

   // The quaternion rides along beside the matrix stages.
   logic signed [15:0] quat_d1_ff [4];
   logic signed [15:0] quat_d2_ff [4];
   logic signed [15:0] quat_d3_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         quat_d1_ff <= quat_ff;
         quat_d2_ff <= quat_d1_ff;
         quat_d3_ff <= quat_d2_ff;
         rsp_item_ff.quat_real <= quat_d3_ff[0];
         rsp_item_ff.quat_i    <= quat_d3_ff[1];
         rsp_item_ff.quat_j    <= quat_d3_ff[2];
         rsp_item_ff.quat_k    <= quat_d3_ff[3];
         rsp_item_ff.rot_x     <= row_round(term_ff[0], term_ff[1], term_ff[2]);
         rsp_item_ff.rot_y     <= row_round(term_ff[3], term_ff[4], term_ff[5]);
         rsp_item_ff.rot_z     <= row_round(term_ff[6], term_ff[7], term_ff[8]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `RQVR_ASSERT_IMPLIES(a_empty_out_takes_item, !rsp_valid_ff, req_ready)
   `RQVR_ASSERT_IMPLIES(a_roots_in_range, cordic_lane[0].valid, cordic_lane[0].root_ri <= 15'd16384 && cordic_lane[0].root_jk <= 15'd16384)
   `RQVR_ASSERT_NEXT(a_last_stage_lands, term_valid_ff && advance, rsp_valid_ff)
   `RQVR_ASSERT_IMPLIES(a_quat_clamped, rsp_valid_ff, rsp_item_ff.quat_real >= -16'sd16384 && rsp_item_ff.quat_real <= 16'sd16384)

endmodule
